/* rtl/wfba_pkg.sv */
// Package for the worst-fit block allocator: field widths, codes and types.
// No dependencies; every other file of the block refers to it by scoped names.
package wfba_pkg;

  localparam int NUM_BLOCKS_DEF = 16;
  localparam int SIZE_WIDTH_DEF = 16;

  localparam int KIND_W   = 1;
  localparam int BLOCK_W  = 4;
  localparam int VALUE_W  = 16;
  localparam int STATUS_W = 2;
  localparam int ACTIVE_W = 5;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

  typedef enum logic [STATUS_W-1:0] {
    ST_LOADED    = 2'd0,
    ST_ALLOCATED = 2'd1,
    ST_NO_FIT    = 2'd2
  } status_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD    = 1'b0,
    KIND_REQUEST = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_t;

  // search token control bits handed from cell to cell
  typedef struct packed {
    logic valid;
    logic found;
  } token_ctrl_t;

endpackage

/* rtl/wfba_ifs.sv */
// Channel interfaces of the worst-fit block allocator: items, results, setup.
// Depends on wfba_pkg for the field widths.
interface wfba_item_if;
  logic                          valid;
  logic                          ready;
  logic [wfba_pkg::KIND_W-1:0]   kind;
  logic [wfba_pkg::BLOCK_W-1:0]  block_number;
  logic [wfba_pkg::VALUE_W-1:0]  size_value;
  logic                          batch_end;

  modport source (output valid, kind, block_number, size_value, batch_end, input ready);
  modport sink   (input valid, kind, block_number, size_value, batch_end, output ready);
endinterface

interface wfba_result_if;
  logic                          valid;
  logic                          ready;
  logic [wfba_pkg::STATUS_W-1:0] status;
  logic [wfba_pkg::BLOCK_W-1:0]  chosen_block;
  logic [wfba_pkg::VALUE_W-1:0]  size_left;
  logic                          batch_done;

  modport source (output valid, status, chosen_block, size_left, batch_done, input ready);
  modport sink   (input valid, status, chosen_block, size_left, batch_done, output ready);
endinterface

interface wfba_setup_if;
  logic                          valid;
  logic                          ready;
  logic [wfba_pkg::ACTIVE_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* rtl/wfba_cell.sv */
// One cell of the search chain: holds one free-size entry and updates the
// passing search token. Depends on wfba_pkg.
module wfba_cell #(
  parameter int IDX        = 0,
  parameter int NUM_BLOCKS = wfba_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_WIDTH = wfba_pkg::SIZE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [wfba_pkg::ACTIVE_W-1:0]     active_blocks,
  input  logic                              wr_en,
  input  logic [$clog2(NUM_BLOCKS)-1:0]     wr_idx,
  input  logic [SIZE_WIDTH-1:0]             wr_data,
  input  wfba_pkg::token_ctrl_t             tok_in,
  input  logic [SIZE_WIDTH-1:0]             req_in,
  input  logic [$clog2(NUM_BLOCKS)-1:0]     best_idx_in,
  input  logic [SIZE_WIDTH-1:0]             best_size_in,
  output wfba_pkg::token_ctrl_t             tok_out,
  output logic [SIZE_WIDTH-1:0]             req_out,
  output logic [$clog2(NUM_BLOCKS)-1:0]     best_idx_out,
  output logic [SIZE_WIDTH-1:0]             best_size_out
);

  localparam int IDX_W = $clog2(NUM_BLOCKS);

  logic [SIZE_WIDTH-1:0] entry;
  logic                  in_range;
  logic                  take;

  assign in_range = 32'(IDX) < 32'(active_blocks);
  assign take     = tok_in.valid && in_range && (entry >= req_in) &&
                    (!tok_in.found || (entry > best_size_in));

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == IDX_W'(IDX))) begin
      entry <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out.valid <= tok_in.valid;
      tok_out.found <= tok_in.found | take;
    end
  end

  always_ff @(posedge clk) begin
    req_out       <= req_in;
    best_idx_out  <= take ? IDX_W'(IDX) : best_idx_in;
    best_size_out <= take ? entry : best_size_in;
  end

  a_found_fits: assert property (@(posedge clk) disable iff (rst)
    tok_out.valid && tok_out.found |-> best_size_out >= req_out)
    else $error("found token carries a best size below the request");

  a_best_grows: assert property (@(posedge clk) disable iff (rst)
    tok_in.valid && tok_in.found |=> tok_out.found && best_size_out >= $past(best_size_in))
    else $error("best size shrank while passing a cell");

  a_write_lands: assert property (@(posedge clk) disable iff (rst)
    wr_en && (wr_idx == IDX_W'(IDX)) |=> entry == $past(wr_data))
    else $error("entry write lost");

endmodule

/* rtl/worst_fit_block_allocator_unit.sv */
// Worst-fit block allocator, top level: controller plus a chain of cells.
// Depends on wfba_pkg, wfba_ifs (channel interfaces) and wfba_cell.
//
// Usage:
//   items   - input words. kind 0 loads block_number's free size with
//             size_value; kind 1 requests size_value from the active block
//             with the largest free size that still holds it (lowest index
//             on a tie). batch_end is echoed as batch_done.
//   results - one word per item: status, chosen_block, size_left.
//   setup   - writes active_blocks; always ready. Write only while idle.
// Timing:
//   A load writes the table and pending result on accept, then goes to
//   S_RESULT for output. A request sends a token down the NUM_BLOCKS-cell
//   chain, one cell per cycle, then writes back and forms the result.
//   One item is in flight at a time; items.ready is high only when idle.
//   A finished word waits in the output register while the next item runs;
//   if the receiver stalls, the next result waits until that register frees.
// Reset: active_blocks returns to 16, control clears. Table contents are
//   undefined until loaded.
module worst_fit_block_allocator_unit #(
  parameter int NUM_BLOCKS = wfba_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_WIDTH = wfba_pkg::SIZE_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  wfba_item_if.sink      items,
  wfba_result_if.source  results,
  wfba_setup_if.sink     setup
);

  localparam int IDX_W = $clog2(NUM_BLOCKS);

  wfba_pkg::state_t state, state_next;

  logic [wfba_pkg::ACTIVE_W-1:0] active_blocks;

  wfba_pkg::token_ctrl_t   tok_ctrl  [0:NUM_BLOCKS];
  logic [SIZE_WIDTH-1:0]   tok_req   [0:NUM_BLOCKS];
  logic [IDX_W-1:0]        tok_idx   [0:NUM_BLOCKS];
  logic [SIZE_WIDTH-1:0]   tok_best  [0:NUM_BLOCKS];

  logic                    accept;
  logic                    inject;
  logic                    load_hit;
  logic [SIZE_WIDTH-1:0]   diff;

  logic                    wr_en;
  logic [IDX_W-1:0]        wr_idx;
  logic [SIZE_WIDTH-1:0]   wr_data;

  logic                               pend_en;
  wfba_pkg::status_t                  pend_status, pend_status_next;
  logic [wfba_pkg::BLOCK_W-1:0]       pend_block, pend_block_next;
  logic [wfba_pkg::VALUE_W-1:0]       pend_left, pend_left_next;
  logic                               batch;
  logic                               out_load;

  logic                               ov;
  wfba_pkg::status_t                  o_status;
  logic [wfba_pkg::BLOCK_W-1:0]       o_block;
  logic [wfba_pkg::VALUE_W-1:0]       o_left;
  logic                               o_done;

  assign items.ready = (state == wfba_pkg::S_IDLE);
  assign accept      = items.valid && items.ready;
  assign inject      = accept && (items.kind == wfba_pkg::KIND_REQUEST);
  assign load_hit    = 32'(items.block_number) < NUM_BLOCKS;
  assign diff        = tok_best[NUM_BLOCKS] - tok_req[NUM_BLOCKS];

  assign setup.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_blocks <= wfba_pkg::ACTIVE_RESET;
    end else if (setup.valid && setup.ready) begin
      active_blocks <= setup.data;
    end
  end

  // chain head
  assign tok_ctrl[0].valid = inject;
  assign tok_ctrl[0].found = 1'b0;
  assign tok_req[0]        = SIZE_WIDTH'(items.size_value);
  assign tok_idx[0]        = '0;
  assign tok_best[0]       = '0;

  for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
    wfba_cell #(
      .IDX        (i),
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_WIDTH (SIZE_WIDTH)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .active_blocks (active_blocks),
      .wr_en         (wr_en),
      .wr_idx        (wr_idx),
      .wr_data       (wr_data),
      .tok_in        (tok_ctrl[i]),
      .req_in        (tok_req[i]),
      .best_idx_in   (tok_idx[i]),
      .best_size_in  (tok_best[i]),
      .tok_out       (tok_ctrl[i+1]),
      .req_out       (tok_req[i+1]),
      .best_idx_out  (tok_idx[i+1]),
      .best_size_out (tok_best[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wfba_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    wr_en            = 1'b0;
    wr_idx           = IDX_W'(items.block_number);
    wr_data          = SIZE_WIDTH'(items.size_value);
    pend_en          = 1'b0;
    pend_status_next = wfba_pkg::ST_LOADED;
    pend_block_next  = items.block_number;
    pend_left_next   = '0;
    out_load         = 1'b0;
    case (state)
      wfba_pkg::S_IDLE: begin
        if (accept) begin
          if (items.kind == wfba_pkg::KIND_LOAD) begin
            wr_en          = load_hit;
            pend_en        = 1'b1;
            pend_left_next = load_hit ? wfba_pkg::VALUE_W'(wr_data) : '0;
            state_next     = wfba_pkg::S_RESULT;
          end else begin
            state_next = wfba_pkg::S_SCAN;
          end
        end
      end
      wfba_pkg::S_SCAN: begin
        if (tok_ctrl[NUM_BLOCKS].valid) begin
          pend_en    = 1'b1;
          state_next = wfba_pkg::S_RESULT;
          if (tok_ctrl[NUM_BLOCKS].found) begin
            wr_en            = 1'b1;
            wr_idx           = tok_idx[NUM_BLOCKS];
            wr_data          = diff;
            pend_status_next = wfba_pkg::ST_ALLOCATED;
            pend_block_next  = wfba_pkg::BLOCK_W'(tok_idx[NUM_BLOCKS]);
            pend_left_next   = wfba_pkg::VALUE_W'(diff);
          end else begin
            pend_status_next = wfba_pkg::ST_NO_FIT;
            pend_block_next  = '0;
            pend_left_next   = '0;
          end
        end
      end
      wfba_pkg::S_RESULT: begin
        if (!ov || results.ready) begin
          out_load   = 1'b1;
          state_next = wfba_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = wfba_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      batch <= items.batch_end;
    end
    if (pend_en) begin
      pend_status <= pend_status_next;
      pend_block  <= pend_block_next;
      pend_left   <= pend_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (out_load) begin
      ov <= 1'b1;
    end else if (results.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_status <= pend_status;
      o_block  <= pend_block;
      o_left   <= pend_left;
      o_done   <= batch;
    end
  end

  assign results.valid        = ov;
  assign results.status       = o_status;
  assign results.chosen_block = o_block;
  assign results.size_left    = o_left;
  assign results.batch_done   = o_done;

  a_scan_length: assert property (@(posedge clk) disable iff (rst)
    inject |-> ##NUM_BLOCKS tok_ctrl[NUM_BLOCKS].valid)
    else $error("search token did not leave the chain on time");

  a_token_in_scan: assert property (@(posedge clk) disable iff (rst)
    tok_ctrl[NUM_BLOCKS].valid |-> state == wfba_pkg::S_SCAN)
    else $error("search token arrived outside a scan");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    out_load |-> $past(state) == wfba_pkg::S_RESULT || $past(pend_en))
    else $error("result issued without a finished item");

endmodule
